// ----- design/glc_pkg.sv -----
// shared types, sizes and command codes of the glauber collision counter
package glc_pkg;

    // table capacity and coordinate width
    localparam int MAX_NUCLEONS = 256;
    localparam int COORD_BITS   = 16;

    localparam int IDX_W = (MAX_NUCLEONS > 1) ? $clog2(MAX_NUCLEONS) : 1;
    localparam int CNT_W = $clog2(MAX_NUCLEONS + 1);

    // field widths of the transactions
    localparam int IN_W     = 16;
    localparam int COLL_W   = 17;
    localparam int PART_W   = 10;
    localparam int RADIUS_W = 34;

    // datapath widths of the pair test
    localparam int MAG_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int CMP_W = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1001320);

    // command codes
    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]             command;
        logic signed [IN_W-1:0] pos_x;
        logic signed [IN_W-1:0] pos_y;
    } item_t;

    typedef struct packed {
        logic [COLL_W-1:0] collision_count;
        logic [PART_W-1:0] participant_count;
        logic              overflow;
    } result_t;

    // one stored nucleon position
    typedef struct packed {
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // bookkeeping that rides along with a pair through the pipeline
    typedef struct packed {
        logic [IDX_W-1:0] j;
        logic             row_first;
    } pair_tag_t;

    typedef struct packed {
        logic      valid;
        logic      hit;
        pair_tag_t tag;
    } pair_res_t;

    // low COORD_BITS bits of the input field
    function automatic logic [COORD_BITS-1:0] to_coord(input logic [IN_W-1:0] raw);
        return COORD_BITS'(raw);
    endfunction

endpackage

// ----- design/glc_ram.sv -----
// generic single write port ram with registered read
module glc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/glc_pair_unit.sv -----
// three stage pair test: differences, squares, sum and radius compare
module glc_pair_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  glc_pkg::pair_tag_t            in_tag,
    input  glc_pkg::entry_t               entry_a,
    input  glc_pkg::entry_t               entry_b,
    input  logic [glc_pkg::RADIUS_W-1:0]  radius_sq,
    output glc_pkg::pair_res_t            res,
    output logic [glc_pkg::IDX_W-1:0]     early_j,
    output logic                          active
);
    import glc_pkg::*;

    logic signed [COORD_BITS:0] dx, dy;
    logic [MAG_W-1:0]           mag_x_next, mag_y_next;
    logic [SUM_W-1:0]           sum;
    logic                       hit_next;

    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg;
    pair_tag_t        s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [MAG_W-1:0] mag_x_reg, mag_y_reg;
    logic [SQ_W-1:0]  sq_x_reg, sq_y_reg;
    logic             hit_reg;

    // sign extended differences and their magnitudes
    always_comb
    begin
        dx = $signed({entry_a.x[COORD_BITS-1], entry_a.x})
           - $signed({entry_b.x[COORD_BITS-1], entry_b.x});
        dy = $signed({entry_a.y[COORD_BITS-1], entry_a.y})
           - $signed({entry_b.y[COORD_BITS-1], entry_b.y});
        mag_x_next = dx[COORD_BITS] ? MAG_W'(-dx) : MAG_W'(dx);
        mag_y_next = dy[COORD_BITS] ? MAG_W'(-dy) : MAG_W'(dy);
        sum      = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg);
        hit_next = CMP_W'(sum) < CMP_W'(radius_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= in_tag;
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;
        s2_tag_reg <= s1_tag_reg;
        sq_x_reg   <= mag_x_reg * mag_x_reg;
        sq_y_reg   <= mag_y_reg * mag_y_reg;
        s3_tag_reg <= s2_tag_reg;
        hit_reg    <= hit_next;
    end

    assign res.valid = s3_valid_reg;
    assign res.hit   = hit_reg;
    assign res.tag   = s3_tag_reg;
    // b index of the pair that leaves the pipeline next cycle
    assign early_j   = s2_tag_reg.j;
    assign active    = s1_valid_reg | s2_valid_reg | s3_valid_reg;

endmodule

// ----- design/glauber_collision_counter_core.sv -----
// top level: command sequencer, nucleon tables and collision tally
//
// loads (command 0 into table a, 1 into table b): start is taken whenever
// busy is low, and a load into a full table is dropped and sets the overflow
// flag until the next compute. a compute (command 2) walks every a-b pair
// through one pair pipeline that tests one pair per cycle, reading both
// tables every cycle; busy stays high while each pair is issued, read from
// the tables, passed through three pipeline stages and tallied, and until
// the result is emitted (at once when either table is empty). the result
// transaction is shown as busy falls, for exactly one cycle with done high;
// the receiver cannot stall it. the b participant marks live in a one-bit
// ram that is cleared entry by entry as table b is loaded; it is read in the
// cycle before the tally, with the previous mark write forwarded. after the
// result the tables, counts, participant marks and overflow flag are empty
// again; interaction_radius_sq keeps its value; write it with cfg_wr_en only
// while busy is low (the block does not enforce this). command 3 is ignored.
module glauber_collision_counter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  glc_pkg::item_t                item,
    output logic                          busy,
    output logic                          done,
    output glc_pkg::result_t              result,
    input  logic                          cfg_wr_en,
    input  logic [glc_pkg::RADIUS_W-1:0]  cfg_wr_data
);
    import glc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_NUCLEONS);
    localparam logic [COLL_W-1:0] COLL_MAX = '1;
    localparam logic [PART_W-1:0] PART_MAX = '1;

    state_t                 state_reg, state_next;
    logic [RADIUS_W-1:0]    radius_reg, radius_next;
    logic [CNT_W-1:0]       count_a_reg, count_a_next;
    logic [CNT_W-1:0]       count_b_reg, count_b_next;
    logic                   overflow_reg, overflow_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic                   rd_valid_reg, rd_valid_next;
    pair_tag_t              rd_tag_reg, rd_tag_next;
    logic [COLL_W-1:0]      coll_reg, coll_next;
    logic [PART_W-1:0]      part_reg, part_next;
    logic                   a_hit_reg, a_hit_next;
    logic                   fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]       fwd_j_reg, fwd_j_next;
    logic                   done_reg, done_next;
    result_t                result_reg, result_next;

    logic             wr_a, wr_b;
    entry_t           wr_entry;
    entry_t           entry_a, entry_b;
    pair_res_t        pres;
    logic             pipe_active;
    logic             last_i, last_j;
    logic             a_hit_eff, b_hit_old;
    logic [1:0]       part_add;
    logic [PART_W:0]  part_sum;
    logic             hit_b_wr_en, hit_b_wr_data, hit_b_rd;
    logic [IDX_W-1:0] hit_b_wr_addr, early_j;

    assign wr_entry.x = to_coord(item.pos_x);
    assign wr_entry.y = to_coord(item.pos_y);

    // nucleon tables, written on loads and read at (i, j) during compute
    glc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NUCLEONS)
    ) u_table_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (count_a_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (i_reg),
        .rd_data (entry_a)
    );

    glc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NUCLEONS)
    ) u_table_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (count_b_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (j_reg),
        .rd_data (entry_b)
    );

    // b participant marks: cleared when the b entry is loaded, set on a hit
    assign hit_b_wr_en   = wr_b | (pres.valid & pres.hit);
    assign hit_b_wr_addr = wr_b ? count_b_reg[IDX_W-1:0] : pres.tag.j;
    assign hit_b_wr_data = !wr_b;

    glc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NUCLEONS)
    ) u_hit_b (
        .clk     (clk),
        .wr_en   (hit_b_wr_en),
        .wr_addr (hit_b_wr_addr),
        .wr_data (hit_b_wr_data),
        .rd_addr (early_j),
        .rd_data (hit_b_rd)
    );

    glc_pair_unit u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .in_tag    (rd_tag_reg),
        .entry_a   (entry_a),
        .entry_b   (entry_b),
        .radius_sq (radius_reg),
        .res       (pres),
        .early_j   (early_j),
        .active    (pipe_active)
    );

    // end of a row of b and end of the whole walk
    assign last_j = ((CNT_W + 1)'(j_reg) + 1'b1) == (CNT_W + 1)'(count_b_reg);
    assign last_i = ((CNT_W + 1)'(i_reg) + 1'b1) == (CNT_W + 1)'(count_a_reg);

    // participant bookkeeping: the a mark only lives for the current row,
    // the b marks persist over the whole walk; a mark written last cycle
    // is not yet in the ram read data, so it is forwarded
    assign a_hit_eff = pres.tag.row_first ? 1'b0 : a_hit_reg;
    assign b_hit_old = hit_b_rd | (fwd_valid_reg && (fwd_j_reg == pres.tag.j));
    assign part_add  = 2'({1'b0, !a_hit_eff}) + 2'({1'b0, !b_hit_old});
    assign part_sum  = (PART_W + 1)'(part_reg) + (PART_W + 1)'(part_add);

    always_comb
    begin
        state_next     = state_reg;
        radius_next    = cfg_wr_en ? cfg_wr_data : radius_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        overflow_next  = overflow_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rd_valid_next  = 1'b0;
        rd_tag_next    = rd_tag_reg;
        coll_next      = coll_reg;
        part_next      = part_reg;
        a_hit_next     = a_hit_reg;
        fwd_valid_next = pres.valid && pres.hit;
        fwd_j_next     = pres.tag.j;
        done_next      = 1'b0;
        result_next    = result_reg;
        wr_a           = 1'b0;
        wr_b           = 1'b0;

        // tally of pairs leaving the pipeline
        if (pres.valid)
        begin
            a_hit_next = a_hit_eff | pres.hit;
            if (pres.hit)
            begin
                if (coll_reg != COLL_MAX)
                begin
                    coll_next = coll_reg + 1'b1;
                end
                part_next = (part_sum > (PART_W + 1)'(PART_MAX)) ? PART_MAX
                                                                  : PART_W'(part_sum);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (item.command)
                        CMD_LOAD_A:
                        begin
                            if (count_a_reg == CNT_FULL)
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                wr_a         = 1'b1;
                                count_a_next = count_a_reg + 1'b1;
                            end
                        end
                        CMD_LOAD_B:
                        begin
                            if (count_b_reg == CNT_FULL)
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                wr_b         = 1'b1;
                                count_b_next = count_b_reg + 1'b1;
                            end
                        end
                        CMD_COMPUTE:
                        begin
                            i_next = '0;
                            j_next = '0;
                            if (count_a_reg == '0 || count_b_reg == '0)
                            begin
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // issue pair (i, j); table data comes back next cycle
                rd_valid_next         = 1'b1;
                rd_tag_next.j         = j_reg;
                rd_tag_next.row_first = (j_reg == '0);
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // emit once the last pair has been tallied, then empty the event
                if (!rd_valid_reg && !pipe_active)
                begin
                    done_next                     = 1'b1;
                    result_next.collision_count   = coll_reg;
                    result_next.participant_count = part_reg;
                    result_next.overflow          = overflow_reg;
                    count_a_next  = '0;
                    count_b_next  = '0;
                    overflow_next = 1'b0;
                    coll_next     = '0;
                    part_next     = '0;
                    a_hit_next    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radius_reg    <= RADIUS_RESET;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            overflow_reg  <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            coll_reg      <= '0;
            part_reg      <= '0;
            a_hit_reg     <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radius_reg    <= radius_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            overflow_reg  <= overflow_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rd_valid_reg  <= rd_valid_next;
            coll_reg      <= coll_next;
            part_reg      <= part_next;
            a_hit_reg     <= a_hit_next;
            fwd_valid_reg <= fwd_valid_next;
            done_reg      <= done_next;
        end
    end

    // result, tag and forward index payload, no reset needed
    always_ff @(posedge clk)
    begin
        rd_tag_reg <= rd_tag_next;
        result_reg <= result_next;
        fwd_j_reg  <= fwd_j_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // the result transaction leaves the block idle with an empty event
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result shown while not idle");

    a_done_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (count_a_reg == '0 && count_b_reg == '0 && !overflow_reg
                      && coll_reg == '0 && part_reg == '0))
        else $error("event not emptied after result");

    // no pair in flight outside a compute
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_valid_reg && !pipe_active))
        else $error("pair pipeline active while idle");

    // tables are only written by loads taken while idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_a || wr_b) |-> (state_reg == ST_IDLE && start))
        else $error("table write outside a load");

    // mark clears on load never meet a mark set from the tally
    a_mark_port: assert property (@(posedge clk) disable iff (!rst_n)
        wr_b |-> !pres.valid)
        else $error("mark ram write collision");

endmodule

// ----- tb/sv/glauber_tally_checker.sv -----
// checker that predicts collision and participant tallies and compares each result transaction
module glauber_tally_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  glc_pkg::item_t               item,
    input  logic                         busy,
    input  logic                         done,
    input  glc_pkg::result_t             result,
    input  logic                         cfg_wr_en,
    input  logic [glc_pkg::RADIUS_W-1:0] cfg_wr_data,
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen
);
    import glc_pkg::*;

    localparam int unsigned COLL_CAP = (1 << COLL_W) - 1;
    localparam int unsigned PART_CAP = (1 << PART_W) - 1;

    // shadow copy of the event being assembled
    logic signed [COORD_BITS-1:0] ax [MAX_NUCLEONS];
    logic signed [COORD_BITS-1:0] ay [MAX_NUCLEONS];
    logic signed [COORD_BITS-1:0] bx [MAX_NUCLEONS];
    logic signed [COORD_BITS-1:0] by [MAX_NUCLEONS];
    bit                           marked_a [MAX_NUCLEONS];
    bit                           marked_b [MAX_NUCLEONS];
    int unsigned                  fill_a;
    int unsigned                  fill_b;
    bit                           dropped;
    logic [RADIUS_W-1:0]          radius_sq;

    result_t expected_tallies [$];
    int      reported;

    task automatic clear_event();
        for (int k = 0; k < MAX_NUCLEONS; k++)
        begin
            marked_a[k] = 1'b0;
            marked_b[k] = 1'b0;
        end
        fill_a  = 0;
        fill_b  = 0;
        dropped = 1'b0;
    endtask

    task automatic store_nucleon(input bit into_b, input item_t t);
        if (!into_b)
        begin
            if (fill_a >= MAX_NUCLEONS)
                dropped = 1'b1;
            else
            begin
                ax[fill_a] = t.pos_x[COORD_BITS-1:0];
                ay[fill_a] = t.pos_y[COORD_BITS-1:0];
                fill_a++;
            end
        end
        else
        begin
            if (fill_b >= MAX_NUCLEONS)
                dropped = 1'b1;
            else
            begin
                bx[fill_b] = t.pos_x[COORD_BITS-1:0];
                by[fill_b] = t.pos_y[COORD_BITS-1:0];
                fill_b++;
            end
        end
    endtask

    // walk every a-b pair, exact integer distance test
    function automatic result_t tally_event();
        result_t         r;
        int unsigned     coll;
        int unsigned     part;
        longint          dx;
        longint          dy;
        longint unsigned d2;
        longint unsigned lim;
        coll = 0;
        part = 0;
        lim  = radius_sq;
        for (int i = 0; i < fill_a; i++)
        begin
            for (int j = 0; j < fill_b; j++)
            begin
                dx = longint'(ax[i]) - longint'(bx[j]);
                dy = longint'(ay[i]) - longint'(by[j]);
                d2 = dx * dx + dy * dy;
                if (d2 < lim)
                begin
                    if (coll < COLL_CAP)
                        coll++;
                    if (!marked_a[i])
                    begin
                        marked_a[i] = 1'b1;
                        if (part < PART_CAP)
                            part++;
                    end
                    if (!marked_b[j])
                    begin
                        marked_b[j] = 1'b1;
                        if (part < PART_CAP)
                            part++;
                    end
                end
            end
        end
        r.collision_count   = COLL_W'(coll);
        r.participant_count = PART_W'(part);
        r.overflow          = dropped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            clear_event();
            radius_sq = RADIUS_RESET;
            expected_tallies.delete();
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
            reported     = 0;
        end
        else
        begin
            if (done)
            begin
                results_seen++;
                if (expected_tallies.size() == 0)
                begin
                    fail_count++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("unexpected result: coll %0d part %0d ovf %0b",
                                 result.collision_count, result.participant_count,
                                 result.overflow);
                    end
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    if (result.collision_count !== want.collision_count ||
                        result.participant_count !== want.participant_count ||
                        result.overflow !== want.overflow)
                    begin
                        fail_count++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("mismatch: expected coll %0d part %0d ovf %0b,",
                                     want.collision_count, want.participant_count,
                                     want.overflow);
                            $display("          got coll %0d part %0d ovf %0b",
                                     result.collision_count,
                                     result.participant_count, result.overflow);
                        end
                    end
                end
            end
            if (cfg_wr_en)
                radius_sq = cfg_wr_data;
            if (start && !busy)
            begin
                case (item.command)
                    CMD_LOAD_A:  store_nucleon(1'b0, item);
                    CMD_LOAD_B:  store_nucleon(1'b1, item);
                    CMD_COMPUTE:
                    begin
                        expected_tallies = {expected_tallies, tally_event()};
                        clear_event();
                    end
                    default: ;
                endcase
            end
            pending = expected_tallies.size();
        end
    end

endmodule

// ----- tb/sv/glauber_collision_counter_core_tb.sv -----
// testbench top: clock, reset, stimulus and verdict for the glauber collision counter
module glauber_collision_counter_core_tb;
    import glc_pkg::*;

    // command 3 is not decoded by the block
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    // random part length and the calm stretch at its end with no idling
    localparam int RANDOM_ITEMS = 1650;
    localparam int CALM_TAIL    = 200;

    localparam logic [RADIUS_W-1:0] RADIUS_FULL = '1;

    logic                clk;
    logic                rst_n;
    logic                start;
    item_t               item;
    logic                busy;
    logic                done;
    result_t             result;
    logic                cfg_wr_en;
    logic [RADIUS_W-1:0] cfg_wr_data;

    int fail_count;
    int pending;
    int results_seen;

    // stimulus bookkeeping
    int items_sent;
    int events_run;
    int radius_settings;
    bit idle_on;

    // cluster spreads in coordinate lsbs; -1 means uniform over the whole field
    int spreads [6] = '{16, 256, 1024, 4096, 16384, -1};

    glauber_collision_counter_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    glauber_tally_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .done         (done),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always #2 clk = ~clk;

    // hard stop well beyond the slowest legal run (one full 256 x 256 compute included)
    initial
    begin : watchdog
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // one transaction: called at a falling edge, returns at the falling edge after acceptance.
    // start is only ever raised here, so a back-to-back transaction keeps it high
    task automatic send(input logic [1:0] cmd, input logic [IN_W-1:0] x,
                        input logic [IN_W-1:0] y);
        item_t t;
        bit    taken;
        t.command = cmd;
        t.pos_x   = x;
        t.pos_y   = y;
        start <= 1'b1;
        item  <= t;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        if (cmd != CMD_IGNORED)
            items_sent++;
    endtask

    // sender idles for a burst of cycles
    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic gap();
        if (idle_on && $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 17));
    endtask

    // hold off until every predicted result has come out and the block is idle
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0 || busy);
    endtask

    // register write only between events, after the block settles
    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        wait_drained();
        repeat (8) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        radius_settings++;
    endtask

    function automatic logic [IN_W-1:0] near(input int center, input int spread);
        if (spread < 0)
            return IN_W'($urandom);
        return IN_W'(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic logic [RADIUS_W-1:0] pick_radius();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return RADIUS_FULL;
            2:       return RADIUS_W'($urandom_range(0, 4096));
            3:       return RADIUS_W'({$urandom, $urandom});
            default: return RADIUS_W'($urandom_range(100000, 20000000));
        endcase
    endfunction

    // one event: interleaved loads around a random center, some ignored commands as
    // noise, then the compute unless the sequence is left open on purpose
    task automatic run_event(input int na, input int nb, input int spread, input bit close_it);
        int la;
        int lb;
        int cx;
        int cy;
        bit to_a;
        la = 0;
        lb = 0;
        cx = $urandom_range(0, 65535);
        cy = $urandom_range(0, 65535);
        while (la < na || lb < nb)
        begin
            gap();
            if ($urandom_range(0, 15) == 0)
                send(CMD_IGNORED, IN_W'($urandom), IN_W'($urandom));
            to_a = (lb >= nb) || (la < na && $urandom_range(0, 1) == 1);
            if (to_a)
            begin
                send(CMD_LOAD_A, near(cx, spread), near(cy, spread));
                la++;
            end
            else
            begin
                send(CMD_LOAD_B, near(cx, spread), near(cy, spread));
                lb++;
            end
        end
        if (close_it)
        begin
            gap();
            send(CMD_COMPUTE, IN_W'($urandom), IN_W'($urandom));
            events_run++;
        end
    endtask

    initial
    begin : stimulus
        int  base;
        int  done_items;
        bit  full_event_done;
        bit  overflow_a_done;
        bit  calm;
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        items_sent      = 0;
        events_run      = 0;
        radius_settings = 0;
        idle_on         = 1'b1;
        full_event_done = 1'b0;
        overflow_a_done = 1'b0;
        calm            = 1'b0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, radius at its reset value first
        // compute with both tables empty, then with table b empty
        send(CMD_COMPUTE, '0, '0);
        send(CMD_LOAD_A, '0, '0);
        send(CMD_COMPUTE, '0, '0);
        // one pair just inside the radius, one just outside, ignored command between
        send(CMD_LOAD_A, '0, '0);
        send(CMD_LOAD_B, 16'd1000, '0);
        send(CMD_LOAD_B, '0, 16'd1001);
        send(CMD_IGNORED, '1, '1);
        send(CMD_COMPUTE, '1, '0);
        // corner coordinates, far apart at the default radius
        send(CMD_LOAD_A, 16'h8000, 16'h8000);
        send(CMD_LOAD_A, 16'h7fff, 16'h8000);
        send(CMD_LOAD_B, 16'h7fff, 16'h7fff);
        send(CMD_LOAD_B, 16'h8000, 16'h7fff);
        send(CMD_COMPUTE, '0, '0);
        // full-scale radius: even the largest possible distance collides
        write_radius(RADIUS_FULL);
        send(CMD_LOAD_A, 16'h8000, 16'h8000);
        send(CMD_LOAD_A, 16'h7fff, 16'h8000);
        send(CMD_LOAD_B, 16'h7fff, 16'h7fff);
        send(CMD_LOAD_B, 16'h8000, 16'h7fff);
        send(CMD_COMPUTE, '0, '0);
        // distance squared equal to the radius must not count
        write_radius(RADIUS_W'(25));
        send(CMD_LOAD_A, '0, '0);
        send(CMD_LOAD_B, 16'd3, 16'd4);
        send(CMD_LOAD_B, 16'd3, 16'd3);
        send(CMD_COMPUTE, '0, '0);
        // zero radius: coincident nucleons do not collide
        write_radius('0);
        send(CMD_LOAD_A, 16'd5, 16'd5);
        send(CMD_LOAD_B, 16'd5, 16'd5);
        send(CMD_COMPUTE, '0, '0);
        events_run += 7;
        write_radius(RADIUS_RESET);

        // random part
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            done_items = items_sent - base;
            calm       = (done_items >= RANDOM_ITEMS - CALM_TAIL);
            if (calm)
                idle_on = 1'b0;
            else if ($urandom_range(0, 7) == 0)
                idle_on = ($urandom_range(0, 2) != 0);

            if (!full_event_done && done_items >= 300)
            begin
                // both tables past capacity, everything collides: largest tallies
                write_radius(RADIUS_FULL);
                run_event(MAX_NUCLEONS + 2, MAX_NUCLEONS + 2, 64, 1'b1);
                full_event_done = 1'b1;
            end
            else if (!overflow_a_done && done_items >= 900)
            begin
                // only table a overflows, small table b keeps the compute short
                run_event(MAX_NUCLEONS + 1, 2, spreads[$urandom_range(0, 3)], 1'b1);
                overflow_a_done = 1'b1;
            end
            else
            begin
                if (!calm && $urandom_range(0, 9) == 0)
                    write_radius(pick_radius());
                else if (!calm && $urandom_range(0, 14) == 0)
                    wait_drained();
                run_event($urandom_range(0, 10), $urandom_range(0, 10),
                          spreads[$urandom_range(0, 5)], $urandom_range(0, 19) != 0);
            end
        end

        // trailing loads with no compute behind them: nothing may come out
        send(CMD_LOAD_A, IN_W'($urandom), IN_W'($urandom));
        send(CMD_LOAD_B, IN_W'($urandom), IN_W'($urandom));

        wait_drained();
        repeat (64) @(negedge clk);

        $display("summary: %0d load/compute transactions, %0d events computed, %0d results seen",
                 items_sent, events_run, results_seen);
        $display("summary: %0d radius settings from zero to full scale, tables past capacity",
                 radius_settings);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- glauber_collision_counter_core.f -----
design/glc_pkg.sv
design/glc_ram.sv
design/glc_pair_unit.sv
design/glauber_collision_counter_core.sv
tb/sv/glauber_tally_checker.sv
tb/sv/glauber_collision_counter_core_tb.sv
